/* hdl/dtti_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtti_pkg
// shared types and character constants for the decimal text to integer block
// ----------------------------------------------------------------------------
package dtti_pkg;

    localparam int CHAR_W   = 8;
    localparam int NUMBER_W = 32;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;

    localparam logic MODE_SIGNED = 1'b0;
    localparam logic MODE_BYTE   = 1'b1;

    typedef enum logic [1:0]
    {
        PH_LEAD  = 2'd0,
        PH_NUM   = 2'd1,
        PH_TRAIL = 2'd2
    } phase_t;

    typedef struct packed
    {
        logic [CHAR_W-1:0] char_code;
        logic              end_of_text;
    } in_item_t;

    typedef struct packed
    {
        logic [NUMBER_W-1:0] number;
        logic                bad_text;
    } result_t;

endpackage

`default_nettype wire

/* hdl/dtti_in_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtti_in_reg
// input register; holds an end request while the result register is full
// ----------------------------------------------------------------------------
module dtti_in_reg
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,
    input  wire logic                 s_axis_tlast,
    input  wire logic                 out_busy,
    output logic                      item_fire,
    output dtti_pkg::in_item_t        item
);

    logic               valid_reg;
    dtti_pkg::in_item_t item_reg;
    logic               take;

    // only an end request needs a free result slot
    assign item_fire     = valid_reg && !(item_reg.end_of_text && out_busy);
    assign s_axis_tready = !valid_reg || item_fire;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_fire)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.char_code   <= s_axis_tdata;
            item_reg.end_of_text <= s_axis_tlast;
        end
    end

endmodule

`default_nettype wire

/* hdl/dtti_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtti_scan
// text scan state, times-ten accumulate and result forming
// ----------------------------------------------------------------------------
module dtti_scan
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic                 cfg_wr_data,
    input  wire logic                 item_fire,
    input  wire dtti_pkg::in_item_t   item,
    output logic                      res_valid,
    output dtti_pkg::result_t         res
);

    logic                                mode_reg;
    dtti_pkg::phase_t                    phase_reg;
    dtti_pkg::phase_t                    phase_next;
    logic                                neg_reg;
    logic                                neg_next;
    logic [dtti_pkg::NUMBER_W-1:0]       acc_reg;
    logic [dtti_pkg::NUMBER_W-1:0]       acc_next;
    logic                                err_reg;
    logic                                err_next;
    logic [dtti_pkg::CHAR_W-1:0]         digit;
    logic [dtti_pkg::NUMBER_W-1:0]       acc_step;
    logic                                is_digit;
    logic                                is_blank;
    logic                                is_sign;
    logic                                in_number;

    assign digit    = item.char_code - dtti_pkg::CHAR_ZERO;
    assign acc_step = {acc_reg[dtti_pkg::NUMBER_W-4:0], 3'b000}
                    + {acc_reg[dtti_pkg::NUMBER_W-2:0], 1'b0}
                    + {{(dtti_pkg::NUMBER_W-dtti_pkg::CHAR_W){1'b0}}, digit};

    always_comb
    begin
        is_digit  = item.char_code inside {[dtti_pkg::CHAR_ZERO:dtti_pkg::CHAR_NINE]};
        is_blank  = item.char_code inside {dtti_pkg::CHAR_SPACE, dtti_pkg::CHAR_TAB,
                                           dtti_pkg::CHAR_LF};
        is_sign   = item.char_code inside {dtti_pkg::CHAR_MINUS, dtti_pkg::CHAR_PLUS};
        in_number = (phase_reg == dtti_pkg::PH_LEAD) || (phase_reg == dtti_pkg::PH_NUM);
    end

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        if (item.end_of_text)
        begin
            phase_next = dtti_pkg::PH_LEAD;
            neg_next   = 1'b0;
            acc_next   = '0;
            err_next   = 1'b0;
        end
        else if (!err_reg)
        begin
            if (is_digit)
            begin
                if (in_number)
                begin
                    acc_next   = acc_step;
                    phase_next = dtti_pkg::PH_NUM;
                end
                else
                begin
                    err_next = 1'b1;
                end
            end
            else if (is_blank)
            begin
                if (phase_reg != dtti_pkg::PH_LEAD)
                begin
                    phase_next = dtti_pkg::PH_TRAIL;
                end
            end
            else if (is_sign && (mode_reg == dtti_pkg::MODE_SIGNED)
                     && (phase_reg == dtti_pkg::PH_LEAD))
            begin
                neg_next   = (item.char_code == dtti_pkg::CHAR_MINUS);
                phase_next = dtti_pkg::PH_NUM;
            end
            else
            begin
                err_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        res.bad_text = err_reg;
        case (mode_reg)
            dtti_pkg::MODE_BYTE:
            begin
                res.number = err_reg ? {{(dtti_pkg::NUMBER_W-8){1'b0}}, 8'hFF}
                                     : {{(dtti_pkg::NUMBER_W-8){1'b0}}, acc_reg[7:0]};
            end
            default:
            begin
                if (err_reg)
                begin
                    res.number = '1;
                end
                else if (neg_reg)
                begin
                    res.number = '0 - acc_reg;
                end
                else
                begin
                    res.number = acc_reg;
                end
            end
        endcase
    end

    assign res_valid = item_fire && item.end_of_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= dtti_pkg::MODE_SIGNED;
            phase_reg <= dtti_pkg::PH_LEAD;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            err_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (item_fire)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/dtti_out_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dtti_out_reg
// result register on the master side
// ----------------------------------------------------------------------------
module dtti_out_reg
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 res_valid,
    input  wire dtti_pkg::result_t    res,
    output logic                      out_busy,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [31:0]               m_axis_tdata,
    output logic                      m_axis_tuser
);

    logic              valid_reg;
    dtti_pkg::result_t res_reg;

    assign out_busy      = valid_reg && !m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg.number;
    assign m_axis_tuser  = res_reg.bad_text;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

/* hdl/decimal_text_to_integer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_text_to_integer
// parses decimal text, one character per request, into a 32-bit or byte value
// ----------------------------------------------------------------------------
// channel   direction  tdata                 tlast        tuser
// s_axis    in         [7:0] char_code       end_of_text  -
// m_axis    out        [31:0] number         -            [0] bad_text
// cfg       in         cfg_wr_data = parse_mode, written when cfg_wr_en is high
//
// one character per cycle while no end request stalls; a result passes the input register, then the result register
// the times-ten add in the scan stage sets the per-cycle work
// reset clears the scan state, result register and parse_mode (signed)
// only an end request stalls, and only while a result waits on m_axis_tready
// ----------------------------------------------------------------------------
module decimal_text_to_integer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] number
    output logic             m_axis_tuser    // [0] bad_text
);

    logic               out_busy;
    logic               item_fire;
    dtti_pkg::in_item_t item;
    logic               res_valid;
    dtti_pkg::result_t  res;

    dtti_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .out_busy      (out_busy),
        .item_fire     (item_fire),
        .item          (item)
    );

    dtti_scan u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_fire   (item_fire),
        .item        (item),
        .res_valid   (res_valid),
        .res         (res)
    );

    dtti_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .res_valid     (res_valid),
        .res           (res),
        .out_busy      (out_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for decimal_text_to_integer: texts are streamed one
// character per request, a scoreboard model or script row gives each expected
// number and error flag, and each result on m_axis is compared field by field;
// the mode register is rewritten between texts and inside texts while idle
// ----------------------------------------------------------------------------
module tb;

    localparam int ITEM_TARGET  = 1100;
    localparam int DRAIN_CYCLES = 4;
    localparam int TIMEOUT_NS   = 400000;

    typedef struct packed
    {
        logic              mode;
        logic [1:0]        len;
        logic [23:0]       text;
        logic              close;
        logic              has_known;
        dtti_pkg::result_t known;
    } text_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_data   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tuser;

    // scoreboard copy of the parser state
    logic             mode_now = dtti_pkg::MODE_SIGNED;
    dtti_pkg::phase_t scan_now = dtti_pkg::PH_LEAD;
    logic             neg_now  = 1'b0;
    logic [31:0]      acc_now  = '0;
    logic             err_now  = 1'b0;

    dtti_pkg::result_t expected_results[$];
    dtti_pkg::result_t want;
    text_row_t         script[10];
    int                sent       = 0;
    int                mismatches = 0;
    int                gap_pct    = 8;
    int                stall_pct  = 52;

    decimal_text_to_integer dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: number %0d, bad_text %0d",
                       $signed(m_axis_tdata), m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata !== want.number)
                begin
                    $error("number: expected %0d, got %0d",
                           $signed(want.number), $signed(m_axis_tdata));
                    mismatches++;
                end
                if (m_axis_tuser !== want.bad_text)
                begin
                    $error("bad_text: expected %0d, got %0d", want.bad_text, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 2))
            0:       return dtti_pkg::CHAR_SPACE;
            1:       return dtti_pkg::CHAR_TAB;
            default: return dtti_pkg::CHAR_LF;
        endcase
    endfunction

    task automatic scan_char(input logic [7:0] c);
        if (err_now)
            return;
        if (c >= dtti_pkg::CHAR_ZERO && c <= dtti_pkg::CHAR_NINE)
        begin
            if (scan_now == dtti_pkg::PH_LEAD || scan_now == dtti_pkg::PH_NUM)
            begin
                acc_now  = acc_now * 32'd10 + 32'(c - dtti_pkg::CHAR_ZERO);
                scan_now = dtti_pkg::PH_NUM;
            end
            else
                err_now = 1'b1;
        end
        else if (c == dtti_pkg::CHAR_SPACE || c == dtti_pkg::CHAR_TAB
                 || c == dtti_pkg::CHAR_LF)
        begin
            if (scan_now != dtti_pkg::PH_LEAD)
                scan_now = dtti_pkg::PH_TRAIL;
        end
        else if ((c == dtti_pkg::CHAR_MINUS || c == dtti_pkg::CHAR_PLUS)
                 && mode_now == dtti_pkg::MODE_SIGNED
                 && scan_now == dtti_pkg::PH_LEAD)
        begin
            neg_now  = (c == dtti_pkg::CHAR_MINUS);
            scan_now = dtti_pkg::PH_NUM;
        end
        else
            err_now = 1'b1;
    endtask

    task automatic close_text(output dtti_pkg::result_t r);
        if (mode_now == dtti_pkg::MODE_BYTE)
            r.number = err_now ? 32'h0000_00FF : {24'h0, acc_now[7:0]};
        else if (err_now)
            r.number = 32'hFFFF_FFFF;
        else
            r.number = neg_now ? -acc_now : acc_now;
        r.bad_text = err_now;
        scan_now   = dtti_pkg::PH_LEAD;
        neg_now    = 1'b0;
        acc_now    = '0;
        err_now    = 1'b0;
    endtask

    // one request; an end request queues either the typed or the predicted result
    task automatic send_request(input logic [7:0] c, input logic last,
                                input logic typed_valid, input dtti_pkg::result_t typed);
        dtti_pkg::result_t r;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (last)
        begin
            close_text(r);
            expected_results.push_back(typed_valid ? typed : r);
        end
        else
            scan_char(c);
        sent++;
    endtask

    // mode write only once the pipeline has drained
    task automatic set_mode(input logic m);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        mode_now     = m;
    endtask

    task automatic random_text();
        logic [7:0] chars[$];
        int         shape;
        int         n;
        int         pos;
        int         split;
        shape = $urandom_range(0, 9);
        if (shape == 9)
        begin
            // noise
            n = $urandom_range(1, 6);
            repeat (n) chars.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            repeat ($urandom_range(0, 2)) chars.push_back(pick_blank());
            if (mode_now == dtti_pkg::MODE_SIGNED && $urandom_range(0, 2) == 0)
                chars.push_back($urandom_range(0, 1) ? dtti_pkg::CHAR_MINUS
                                                     : dtti_pkg::CHAR_PLUS);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 4);
            repeat (n) chars.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            repeat ($urandom_range(0, 2)) chars.push_back(pick_blank());
            if (shape == 7)
            begin
                // stray sign or any byte somewhere in the text
                pos = $urandom_range(0, chars.size());
                chars.insert(pos, $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                       : dtti_pkg::CHAR_MINUS);
            end
            else if (shape == 8)
            begin
                // more text after trailing whitespace
                chars.push_back(pick_blank());
                chars.push_back($urandom_range(0, 3) == 0 ? dtti_pkg::CHAR_PLUS
                                : dtti_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            end
        end
        split = ($urandom_range(0, 19) == 0) ? $urandom_range(0, chars.size()) : -1;
        foreach (chars[i])
        begin
            if (i == split)
                set_mode(1'($urandom_range(0, 1)));
            send_request(chars[i], 1'b0, 1'b0, '0);
        end
        send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
    endtask

    initial
    begin
        int k;
        int pos;
        script[0] = '{dtti_pkg::MODE_SIGNED, 2'd0, 24'h0, 1'b1, 1'b1, '{32'd0, 1'b0}};
        script[1] = '{dtti_pkg::MODE_SIGNED, 2'd3,
                      {dtti_pkg::CHAR_SPACE, "+", dtti_pkg::CHAR_TAB}, 1'b1, 1'b1,
                      '{32'd0, 1'b0}};
        script[2] = '{dtti_pkg::MODE_SIGNED, 2'd3, "-90", 1'b1, 1'b0, '0};
        script[3] = '{dtti_pkg::MODE_SIGNED, 2'd3, "1 2", 1'b1, 1'b1,
                      '{32'hFFFF_FFFF, 1'b1}};
        script[4] = '{dtti_pkg::MODE_SIGNED, 2'd2, "+-", 1'b1, 1'b1,
                      '{32'hFFFF_FFFF, 1'b1}};
        script[5] = '{dtti_pkg::MODE_SIGNED, 2'd2, "-3", 1'b0, 1'b0, '0};
        script[6] = '{dtti_pkg::MODE_BYTE, 2'd1, "9", 1'b1, 1'b0, '0};
        script[7] = '{dtti_pkg::MODE_BYTE, 2'd1, "-", 1'b1, 1'b1, '{32'h0000_00FF, 1'b1}};
        script[8] = '{dtti_pkg::MODE_BYTE, 2'd1, 24'h00, 1'b1, 1'b1, '{32'h0000_00FF, 1'b1}};
        script[9] = '{dtti_pkg::MODE_BYTE, 2'd1, 24'hFF, 1'b1, 1'b1, '{32'h0000_00FF, 1'b1}};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].mode != mode_now)
                set_mode(script[i].mode);
            for (k = 0; k < int'(script[i].len); k++)
            begin
                pos = int'(script[i].len) - 1 - k;
                send_request(script[i].text[8*pos +: 8], 1'b0, 1'b0, '0);
            end
            if (script[i].close)
                send_request(8'($urandom_range(0, 255)), 1'b1, script[i].has_known,
                             script[i].known);
        end

        while (sent < ITEM_TARGET)
        begin
            case (sent * 3 / ITEM_TARGET)
                0:
                begin
                    gap_pct   = 8;
                    stall_pct = 52;
                end
                1:
                begin
                    gap_pct   = 52;
                    stall_pct = 8;
                end
                default:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
            endcase
            if ($urandom_range(0, 11) == 0)
                set_mode(~mode_now);
            random_text();
        end

        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
